// ----- src/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

  // Data word and iteration counter sizes
  localparam int WORD_W = 64;
  localparam int STEP_W = $clog2(WORD_W);

  // Default stack size
  localparam int STACK_DEPTH_DEF = 16;

  // Command codes
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  // Status codes reported with each result
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FEW  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_NEGB,
    S_DIV,
    S_NEGQ,
    S_WRITE
  } state_t;

  // Stack update applied at write-back
  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_OP
  } wr_kind_t;

endpackage

`default_nettype wire

// ----- src/rpn_alu.sv -----
`default_nettype none

module rpn_alu (
  input  wire logic [rpn_pkg::WORD_W-1:0] a,
  input  wire logic [rpn_pkg::WORD_W-1:0] b,
  input  wire logic                       sub,
  output logic      [rpn_pkg::WORD_W-1:0] sum,
  output logic                            carry
);

  logic [rpn_pkg::WORD_W:0] full;
  logic [rpn_pkg::WORD_W-1:0] b_in;

  // Invert b and add one for subtract; carry high means a >= b unsigned
  assign b_in  = sub ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_in} + {{rpn_pkg::WORD_W{1'b0}}, sub};
  assign sum   = full[rpn_pkg::WORD_W-1:0];
  assign carry = full[rpn_pkg::WORD_W];

endmodule

`default_nettype wire

// ----- src/rpn_stack_mem.sv -----
`default_nettype none

module rpn_stack_mem #(
  parameter int DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [rpn_pkg::WORD_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [rpn_pkg::WORD_W-1:0] rd_data
);

  logic [rpn_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rpn_stack_calculator.sv -----
`default_nettype none

// Push, add, subtract and ignored commands: busy in execute and write-back, then done.
// Multiply: one shift-add step per cycle through the shared adder.
// Divide: one restoring step per cycle plus sign fixes on the same adder.
// A new command may transfer in the cycle that done is high; done lasts one cycle, no stall.
// Synchronous active-high reset empties the stack and clears the last result.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic        [2:0]                 command,
  input  wire logic signed [rpn_pkg::WORD_W-1:0] push_value,
  output logic                                   busy,
  output logic                                   done,
  output logic signed      [rpn_pkg::WORD_W-1:0] top_value,
  output logic             [4:0]                 depth,
  output logic signed      [rpn_pkg::WORD_W-1:0] last_result,
  output logic             [1:0]                 status
);

  localparam int W  = rpn_pkg::WORD_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  rpn_pkg::state_t   state, state_next;
  rpn_pkg::wr_kind_t wr_kind;
  rpn_pkg::status_t  step_status;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     count_m2;
  logic [CW+4:0]     depth_ext;
  logic [W-1:0]      top_reg;
  logic [W-1:0]      top_next;
  logic [W-1:0]      last_value;
  logic [2:0]        cmd;
  logic [W-1:0]      value;
  logic [W-1:0]      res;
  logic [W-1:0]      reg_a;
  logic [W-1:0]      reg_b;
  logic [W-1:0]      reg_c;
  logic              neg_q;
  logic [rpn_pkg::STEP_W-1:0] step_cnt;
  logic              last_step;
  logic [W-1:0]      div_shift;

  logic              ops_ok;
  logic              is_full;
  logic              div_zero;

  logic [W-1:0]      alu_a;
  logic [W-1:0]      alu_b;
  logic              alu_sub;
  logic [W-1:0]      alu_sum;
  logic              alu_carry;

  logic              rd_en;
  logic [W-1:0]      rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  assign busy      = (state != rpn_pkg::S_IDLE);
  assign count_m2  = count - CW'(2);
  assign ops_ok    = (count >= CW'(2));
  assign is_full   = (count >= CW'(STACK_DEPTH));
  assign div_zero  = (top_reg == '0);
  assign last_step = (step_cnt == rpn_pkg::STEP_W'(W - 1));
  assign div_shift = {reg_a[W-2:0], reg_b[W-1]};

  rpn_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_next),
    .rd_en   (rd_en),
    .rd_addr (count_m2[AW-1:0]),
    .rd_data (rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rpn_pkg::S_IDLE: begin
        if (start) begin
          state_next = rpn_pkg::S_EXEC;
        end
      end
      rpn_pkg::S_EXEC: begin
        state_next = rpn_pkg::S_WRITE;
        if (ops_ok && cmd == rpn_pkg::CMD_MUL) begin
          state_next = rpn_pkg::S_MUL;
        end else if (ops_ok && cmd == rpn_pkg::CMD_DIV && !div_zero) begin
          state_next = rpn_pkg::S_NEGB;
        end
      end
      rpn_pkg::S_MUL: begin
        if (last_step) begin
          state_next = rpn_pkg::S_WRITE;
        end
      end
      rpn_pkg::S_NEGB:  state_next = rpn_pkg::S_DIV;
      rpn_pkg::S_DIV: begin
        if (last_step) begin
          state_next = rpn_pkg::S_NEGQ;
        end
      end
      rpn_pkg::S_NEGQ:  state_next = rpn_pkg::S_WRITE;
      rpn_pkg::S_WRITE: state_next = rpn_pkg::S_IDLE;
      default:          state_next = rpn_pkg::S_IDLE;
    endcase
  end

  // Shared adder operands and memory strobes
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    case (state)
      rpn_pkg::S_IDLE: begin
        rd_en = start && ops_ok;
      end
      rpn_pkg::S_EXEC: begin
        if (cmd == rpn_pkg::CMD_DIV) begin
          alu_b   = rd_data;
          alu_sub = 1'b1;
        end else begin
          alu_a   = rd_data;
          alu_b   = top_reg;
          alu_sub = (cmd == rpn_pkg::CMD_SUB);
        end
      end
      rpn_pkg::S_MUL: begin
        alu_a = reg_a;
        alu_b = reg_b;
      end
      rpn_pkg::S_NEGB: begin
        alu_b   = reg_c;
        alu_sub = 1'b1;
      end
      rpn_pkg::S_DIV: begin
        alu_a   = div_shift;
        alu_b   = reg_c;
        alu_sub = 1'b1;
      end
      rpn_pkg::S_NEGQ: begin
        alu_b   = reg_b;
        alu_sub = 1'b1;
      end
      rpn_pkg::S_WRITE: begin
        wr_en = (wr_kind != rpn_pkg::WR_NONE);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Write-back values
  always_comb begin
    count_next = count;
    top_next   = top_reg;
    wr_addr    = count_m2[AW-1:0];
    case (wr_kind)
      rpn_pkg::WR_PUSH: begin
        count_next = count + CW'(1);
        top_next   = value;
        wr_addr    = count[AW-1:0];
      end
      rpn_pkg::WR_OP: begin
        count_next = count - CW'(1);
        top_next   = res;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign depth_ext = (CW + 5)'(count_next);

  // Capture the command on transfer, then run the datapath
  always_ff @(posedge clk) begin
    case (state)
      rpn_pkg::S_IDLE: begin
        if (start) begin
          cmd   <= command;
          value <= push_value;
        end
      end
      rpn_pkg::S_EXEC: begin
        step_cnt    <= '0;
        wr_kind     <= rpn_pkg::WR_NONE;
        step_status <= rpn_pkg::ST_DONE;
        case (cmd)
          rpn_pkg::CMD_PUSH: begin
            if (is_full) begin
              step_status <= rpn_pkg::ST_FULL;
            end else begin
              wr_kind <= rpn_pkg::WR_PUSH;
            end
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
            if (!ops_ok) begin
              step_status <= rpn_pkg::ST_FEW;
            end else begin
              wr_kind <= rpn_pkg::WR_OP;
              res     <= alu_sum;
            end
          end
          rpn_pkg::CMD_MUL: begin
            if (!ops_ok) begin
              step_status <= rpn_pkg::ST_FEW;
            end else begin
              wr_kind <= rpn_pkg::WR_OP;
              reg_a   <= '0;
              reg_b   <= rd_data;
              reg_c   <= top_reg;
            end
          end
          rpn_pkg::CMD_DIV: begin
            if (!ops_ok) begin
              step_status <= rpn_pkg::ST_FEW;
            end else if (div_zero) begin
              step_status <= rpn_pkg::ST_DIV0;
            end else begin
              wr_kind <= rpn_pkg::WR_OP;
              reg_a   <= '0;
              reg_b   <= rd_data[W-1] ? alu_sum : rd_data;
              reg_c   <= top_reg;
              neg_q   <= rd_data[W-1] ^ top_reg[W-1];
            end
          end
          default: begin
            step_status <= rpn_pkg::ST_DONE;
          end
        endcase
      end
      // Shift-add: accumulate multiplicand where the multiplier bit is set
      rpn_pkg::S_MUL: begin
        if (reg_c[0]) begin
          reg_a <= alu_sum;
        end
        reg_b    <= {reg_b[W-2:0], 1'b0};
        reg_c    <= {1'b0, reg_c[W-1:1]};
        step_cnt <= step_cnt + rpn_pkg::STEP_W'(1);
        if (last_step) begin
          res <= reg_c[0] ? alu_sum : reg_a;
        end
      end
      // Take the divisor magnitude
      rpn_pkg::S_NEGB: begin
        if (reg_c[W-1]) begin
          reg_c <= alu_sum;
        end
      end
      // Restoring step: keep the trial remainder when no borrow
      rpn_pkg::S_DIV: begin
        reg_a    <= alu_carry ? alu_sum : div_shift;
        reg_b    <= {reg_b[W-2:0], alu_carry};
        step_cnt <= step_cnt + rpn_pkg::STEP_W'(1);
      end
      // Apply the quotient sign
      rpn_pkg::S_NEGQ: begin
        res <= neg_q ? alu_sum : reg_b;
      end
      rpn_pkg::S_WRITE: begin
        top_reg     <= top_next;
        top_value   <= (count_next == '0) ? '0 : top_next;
        depth       <= depth_ext[4:0];
        last_result <= (wr_kind == rpn_pkg::WR_OP) ? res : last_value;
        status      <= step_status;
      end
      default: begin
        step_cnt <= step_cnt;
      end
    endcase
  end

  // Stack count, last result and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_value <= '0;
      done       <= 1'b0;
    end else begin
      done <= (state == rpn_pkg::S_WRITE);
      if (state == rpn_pkg::S_WRITE) begin
        count <= count_next;
        if (wr_kind == rpn_pkg::WR_OP) begin
          last_value <= res;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/rpn_checker.sv -----
`default_nettype none

module rpn_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic signed [rpn_pkg::WORD_W-1:0] top_value,
  input wire logic        [4:0]                 depth,
  input wire logic        [1:0]                 status
);

  // A transfer always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer did not raise busy");

  // A result comes only out of a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe outside write-back");

  // The strobe is a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // Too few operands means at most one entry
  a_few_depth: assert property (@(posedge clk) disable iff (rst)
    done && status == rpn_pkg::ST_FEW |-> depth < 5'd2)
    else $error("too-few status with deep stack");

  // Divide by zero leaves the zero divisor on top
  a_div0_top: assert property (@(posedge clk) disable iff (rst)
    done && status == rpn_pkg::ST_DIV0 |-> top_value == '0)
    else $error("divide-by-zero status with nonzero top");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .top_value (top_value),
  .depth     (depth),
  .status    (status)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS = 100;

  // Command codes the block decodes as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINUS_ONE = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0]      top;
    logic [4:0]       depth;
    logic [63:0]      last;
    rpn_pkg::status_t status;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
    logic        typed;
    outcome_t    want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic        [2:0]  command;
  logic signed [63:0] push_value;
  logic               busy;
  logic               done;
  logic signed [63:0] top_value;
  logic        [4:0]  depth;
  logic signed [63:0] last_result;
  logic        [1:0]  status;

  // Shadow copy of the calculator state
  logic [63:0] shadow_stack [rpn_pkg::STACK_DEPTH_DEF];
  int          shadow_count = 0;
  logic [63:0] shadow_last = '0;

  outcome_t calc_outcomes[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;

  rpn_stack_calculator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .push_value  (push_value),
    .busy        (busy),
    .done        (done),
    .top_value   (top_value),
    .depth       (depth),
    .last_result (last_result),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Apply one command to the shadow stack and return the outcome it reports
  function automatic outcome_t apply_command(logic [2:0] cmd, logic [63:0] value);
    logic [63:0]      lhs;
    logic [63:0]      rhs;
    logic [63:0]      res;
    logic [63:0]      mag_l;
    logic [63:0]      mag_r;
    logic [63:0]      quo;
    logic             ok;
    rpn_pkg::status_t st;
    outcome_t         o;
    st = rpn_pkg::ST_DONE;
    ok = 1'b1;
    res = '0;
    if (cmd == rpn_pkg::CMD_PUSH) begin
      if (shadow_count >= rpn_pkg::STACK_DEPTH_DEF) begin
        st = rpn_pkg::ST_FULL;
      end else begin
        shadow_stack[shadow_count] = value;
        shadow_count++;
      end
    end else if (cmd <= rpn_pkg::CMD_DIV) begin
      if (shadow_count < 2) begin
        st = rpn_pkg::ST_FEW;
      end else begin
        lhs = shadow_stack[shadow_count - 2];
        rhs = shadow_stack[shadow_count - 1];
        case (cmd)
          rpn_pkg::CMD_ADD: res = lhs + rhs;
          rpn_pkg::CMD_SUB: res = lhs - rhs;
          rpn_pkg::CMD_MUL: res = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              ok = 1'b0;
              st = rpn_pkg::ST_DIV0;
            end else begin
              // divide magnitudes, then restore the sign (truncates toward zero)
              mag_l = lhs[63] ? -lhs : lhs;
              mag_r = rhs[63] ? -rhs : rhs;
              quo = mag_l / mag_r;
              res = (lhs[63] != rhs[63]) ? -quo : quo;
            end
          end
        endcase
        if (ok) begin
          shadow_count--;
          shadow_stack[shadow_count - 1] = res;
          shadow_last = res;
        end
      end
    end
    o.top = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
    o.depth = shadow_count[4:0];
    o.last = shadow_last;
    o.status = st;
    return o;
  endfunction

  // Drive one command and hold it until the block takes the transfer
  task automatic send_command(logic [2:0] cmd, logic [63:0] value, logic typed,
                              outcome_t want);
    outcome_t got;
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    push_value <= value;
    do @(posedge clk); while (busy);
    got = apply_command(cmd, value);
    calc_outcomes.push_back(typed ? want : got);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off until every pending outcome has come back
  task automatic drain_outcomes();
    pause_sender(1);
    while (calc_outcomes.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed sequences: push while shallow, operate while deep
  function automatic logic [2:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if (roll < 9) return 3'($urandom_range(rpn_pkg::CMD_ADD, rpn_pkg::CMD_DIV));
    if (shadow_count < 2) return rpn_pkg::CMD_PUSH;
    if (shadow_count >= rpn_pkg::STACK_DEPTH_DEF)
      return (roll < 25) ? rpn_pkg::CMD_PUSH
                         : 3'($urandom_range(rpn_pkg::CMD_ADD, rpn_pkg::CMD_DIV));
    return (roll < 60) ? rpn_pkg::CMD_PUSH
                       : 3'($urandom_range(rpn_pkg::CMD_ADD, rpn_pkg::CMD_DIV));
  endfunction

  function automatic logic [63:0] pick_value();
    int near_zero;
    near_zero = int'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MOST_NEG;
      2: return MOST_POS;
      3: return MINUS_ONE;
      4, 5: return {{32{near_zero[31]}}, near_zero};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Check each strobed result against the oldest pending outcome
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (calc_outcomes.size() == 0) begin
        flag_mismatch("result with nothing pending");
      end else begin
        want = calc_outcomes.pop_front();
        if (top_value !== want.top)
          flag_mismatch($sformatf("top_value %h, want %h", top_value, want.top));
        if (depth !== want.depth)
          flag_mismatch($sformatf("depth %0d, want %0d", depth, want.depth));
        if (last_result !== want.last)
          flag_mismatch($sformatf("last_result %h, want %h", last_result, want.last));
        if (rpn_pkg::status_t'(status) !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
      end
    end
  end

  initial begin
    row_t rows[$];
    int   i;
    rst = 1'b1;
    start = 1'b0;
    command = rpn_pkg::CMD_PUSH;
    push_value = '0;

    // Special cases up front, then fill the stack to overflow
    rows.push_back('{rpn_pkg::CMD_ADD, '0, 1'b1, '{'0, 5'd0, '0, rpn_pkg::ST_FEW}});
    rows.push_back('{rpn_pkg::CMD_PUSH, MOST_NEG, 1'b1,
                     '{MOST_NEG, 5'd1, '0, rpn_pkg::ST_DONE}});
    rows.push_back('{rpn_pkg::CMD_DIV, '0, 1'b1, '{MOST_NEG, 5'd1, '0, rpn_pkg::ST_FEW}});
    rows.push_back('{rpn_pkg::CMD_PUSH, MINUS_ONE, 1'b1,
                     '{MINUS_ONE, 5'd2, '0, rpn_pkg::ST_DONE}});
    // most negative over minus one wraps
    rows.push_back('{rpn_pkg::CMD_DIV, '0, 1'b1,
                     '{MOST_NEG, 5'd1, MOST_NEG, rpn_pkg::ST_DONE}});
    rows.push_back('{rpn_pkg::CMD_PUSH, '0, 1'b1, '{'0, 5'd2, MOST_NEG, rpn_pkg::ST_DONE}});
    rows.push_back('{rpn_pkg::CMD_DIV, MINUS_ONE, 1'b1,
                     '{'0, 5'd2, MOST_NEG, rpn_pkg::ST_DIV0}});
    rows.push_back('{CMD_SPARE_HI, MOST_POS, 1'b1, '{'0, 5'd2, MOST_NEG, rpn_pkg::ST_DONE}});
    rows.push_back('{CMD_SPARE_LO, '0, 1'b1, '{'0, 5'd2, MOST_NEG, rpn_pkg::ST_DONE}});
    rows.push_back('{rpn_pkg::CMD_PUSH, MOST_POS, 1'b0, '0});
    rows.push_back('{rpn_pkg::CMD_ADD, '0, 1'b0, '0});
    rows.push_back('{rpn_pkg::CMD_SUB, '0, 1'b0, '0});
    rows.push_back('{rpn_pkg::CMD_MUL, '0, 1'b0, '0});
    for (i = 0; i < rpn_pkg::STACK_DEPTH_DEF; i++)
      rows.push_back('{rpn_pkg::CMD_PUSH, 64'(i * 7 - 50), 1'b0, '0});
    rows.push_back('{rpn_pkg::CMD_MUL, '0, 1'b0, '0});
    rows.push_back('{rpn_pkg::CMD_DIV, '0, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      send_command(rows[k].cmd, rows[k].value, rows[k].typed, rows[k].want);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
    end
    drain_outcomes();

    // Random traffic; the final stretch runs back to back
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 149) drain_outcomes();
      send_command(pick_command(), pick_value(), 1'b0, '0);
      if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 17));
    end

    drain_outcomes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
